FILE: rtl/acsd_pkg.sv
// Shared constants, register codes and the CORDIC angle table for the arctangent
// soft-clip waveshaper. Used by acsd_cordic and arctan_soft_clip_distortion.
// No dependencies.
`default_nettype none

package acsd_pkg;

    // Default values for the top-level parameters.
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int CORDIC_STAGES_DEF = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DRIVE  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 8'd3;

    // Register widths, upper limits and reset values.
    localparam int DRIVE_W = 17;
    localparam int RANGE_W = 20;
    localparam int BLEND_W = 17;
    localparam int VOL_W   = 18;

    localparam logic [DRIVE_W-1:0] DRIVE_HIGH  = 17'd65536;
    localparam logic [RANGE_W-1:0] RANGE_HIGH  = 20'd768000;
    localparam logic [BLEND_W-1:0] BLEND_HIGH  = 17'd65536;
    localparam logic [VOL_W-1:0]   VOL_HIGH    = 18'd196608;

    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 17'd26214;
    localparam logic [RANGE_W-1:0] RANGE_RESET = 20'd154;
    localparam logic [BLEND_W-1:0] BLEND_RESET = 17'd32768;
    localparam logic [VOL_W-1:0]   VOL_RESET   = 18'd65536;

    // Unity for the blend weight (Q1.16).
    localparam logic [BLEND_W-1:0] BLEND_ONE = 17'd65536;

    // Combined gain drive * range / 2^8, at most 196608000, fits in 28 bits.
    localparam int G16_W = 28;
    localparam logic [G16_W-1:0] G16_RESET = 28'd15769;

    // The product |x| * g16 shifted down so that x0 sits at 2^29 keeps 42 bits;
    // up to 12 more shifts bring it below 2^30.
    localparam int Q_W    = 42;
    localparam int E_W    = 4;
    localparam int E_MAX  = 12;

    // CORDIC datapath width: x grows to about 2^31.2, angles stay below 2^31.
    localparam int CORDIC_W    = 34;
    localparam int ANG_TAB_LEN = 24;

    typedef struct packed {
        logic valid;
        logic zero;
    } t_cordic_ctl;

    // atan(2^-i) in units where pi/2 is 2^30.
    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acsd_cordic.sv
// Pipelined vectoring CORDIC, one register stage per iteration, returning the
// accumulated angle. Carries the sample and a control struct alongside. Uses acsd_pkg.
`default_nettype none

module acsd_cordic
    import acsd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_cordic_ctl                   i_ctl,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  wire logic signed [CORDIC_W-1:0]    i_x,
    input  wire logic signed [CORDIC_W-1:0]    i_y,
    output t_cordic_ctl                        o_ctl,
    output logic [SAMPLE_BITS-1:0]             o_sample,
    output logic signed [CORDIC_W-1:0]         o_ang
);

    t_cordic_ctl                 r_ctl    [CORDIC_STAGES];
    logic [SAMPLE_BITS-1:0]      r_sample [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  r_x      [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  r_y      [CORDIC_STAGES];
    logic signed [CORDIC_W-1:0]  r_a      [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        t_cordic_ctl                w_ci;
        logic [SAMPLE_BITS-1:0]     w_si;
        logic signed [CORDIC_W-1:0] w_xi;
        logic signed [CORDIC_W-1:0] w_yi;
        logic signed [CORDIC_W-1:0] w_ai;
        logic signed [CORDIC_W-1:0] w_xs;
        logic signed [CORDIC_W-1:0] w_ys;
        logic signed [CORDIC_W-1:0] w_tab;

        if (i == 0) begin : g_first
            assign w_ci = i_ctl;
            assign w_si = i_sample;
            assign w_xi = i_x;
            assign w_yi = i_y;
            assign w_ai = '0;
        end else begin : g_next
            assign w_ci = r_ctl[i-1];
            assign w_si = r_sample[i-1];
            assign w_xi = r_x[i-1];
            assign w_yi = r_y[i-1];
            assign w_ai = r_a[i-1];
        end

        // Arithmetic shifts floor, which matches the truncating shifts of x and y.
        assign w_xs  = w_xi >>> i;
        assign w_ys  = w_yi >>> i;
        assign w_tab = CORDIC_W'(atan_tab(5'(i)));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[i] <= '0;
            end else begin
                r_ctl[i] <= w_ci;
            end
            r_sample[i] <= w_si;
            if (!w_yi[CORDIC_W-1]) begin
                r_x[i] <= w_xi + w_ys;
                r_y[i] <= w_yi - w_xs;
                r_a[i] <= w_ai + w_tab;
            end else begin
                r_x[i] <= w_xi - w_ys;
                r_y[i] <= w_yi + w_xs;
                r_a[i] <= w_ai - w_tab;
            end
        end
    end

    assign o_ctl    = r_ctl[CORDIC_STAGES-1];
    assign o_sample = r_sample[CORDIC_STAGES-1];
    assign o_ang    = r_a[CORDIC_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/arctan_soft_clip_distortion.sv
// Arctangent soft-clip waveshaper top level: gain, normalization, CORDIC, dry/wet
// mix, volume and saturation. Depends on acsd_pkg and acsd_cordic.
//
// A sample is taken at every clock edge where start is high and busy is low; busy
// is low whenever reset is released, so one sample per clock is sustained. Each
// sample produces exactly one result, shown on o_sample_out and o_clipped for a
// single cycle with o_valid high. The sample passes three front-end stages (input
// register, gain multiply, leading-one search), the CORDIC pipeline (one stage per
// iteration, the first also applying the normalizing shift) and four back-end
// stages (angle rounding, mix, volume, saturation). The receiver cannot stall, so
// results must be captured as they appear. Configuration writes are ready
// whenever reset is released and take effect for samples started on the
// following clock.
`default_nettype none

module arctan_soft_clip_distortion
    import acsd_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_in,
    output logic                               o_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                               o_clipped,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + G16_W;
    localparam int S0    = SB - 14;
    localparam int SH    = 31 - SB;
    localparam int MIX_W = SB + 20;
    localparam int M2_W  = MIX_W - 17;
    localparam int PR_W  = M2_W + VOL_W + 1;
    localparam int Y_W   = PR_W - 16;

    localparam logic [CORDIC_W-1:0]        X0_TOP   = CORDIC_W'(1) << 29;
    localparam logic signed [CORDIC_W-1:0] ANG_MAX  = CORDIC_W'(1) << 30;
    localparam logic signed [MIX_W-1:0]    MIX_HALF = MIX_W'(1) << 16;
    localparam logic signed [PR_W-1:0]     Y_HALF   = PR_W'(1) << 15;
    localparam logic signed [Y_W-1:0]      SMAX     = (Y_W'(1) << (SB - 1)) - Y_W'(1);
    localparam logic signed [Y_W-1:0]      SMIN     = -SMAX - Y_W'(1);

    // ---------------------------------------------------------------- config
    logic [DRIVE_W-1:0] r_drive;
    logic [RANGE_W-1:0] r_range;
    logic [BLEND_W-1:0] r_blend;
    logic [VOL_W-1:0]   r_vol;
    logic [G16_W-1:0]   r_g16;
    logic [DRIVE_W+RANGE_W-1:0] w_gain_full;
    logic w_cfg_wr;

    assign o_cfg_ready = i_rst_n;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_gain_full = r_drive * r_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive <= DRIVE_RESET;
            r_range <= RANGE_RESET;
            r_blend <= BLEND_RESET;
            r_vol   <= VOL_RESET;
            r_g16   <= G16_RESET;
        end else begin
            // The gain product is refreshed every cycle; the user must write only when idle (not enforced here).
            r_g16 <= w_gain_full[G16_W+7:8];
            if (w_cfg_wr) begin
                case (i_cfg_index)
                    REG_DRIVE: begin
                        r_drive <= (i_cfg_data[DRIVE_W-1:0] > DRIVE_HIGH)
                                   ? DRIVE_HIGH : i_cfg_data[DRIVE_W-1:0];
                    end
                    REG_RANGE: begin
                        r_range <= (i_cfg_data[RANGE_W-1:0] > RANGE_HIGH)
                                   ? RANGE_HIGH : i_cfg_data[RANGE_W-1:0];
                    end
                    REG_BLEND: begin
                        r_blend <= (i_cfg_data[BLEND_W-1:0] > BLEND_HIGH)
                                   ? BLEND_HIGH : i_cfg_data[BLEND_W-1:0];
                    end
                    REG_VOLUME: begin
                        r_vol <= (i_cfg_data[VOL_W-1:0] > VOL_HIGH)
                                 ? VOL_HIGH : i_cfg_data[VOL_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------- front end
    logic w_accept;
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    logic                 r1_valid;
    logic signed [SB-1:0] r1_x;
    logic [SB-1:0]        w_mag;
    logic [PW-1:0]        n_p;

    logic                 r2_valid;
    logic signed [SB-1:0] r2_x;
    logic [PW-1:0]        r2_p;
    logic [Q_W-1:0]       w_q;
    logic [E_W-1:0]       n_e;

    logic                 r3_valid;
    logic                 r3_zero;
    logic signed [SB-1:0] r3_x;
    logic [Q_W-1:0]       r3_q;
    logic [E_W-1:0]       r3_e;
    logic [Q_W-1:0]       w_q_sh;
    logic [CORDIC_W-1:0]  w_x0;
    logic [CORDIC_W-1:0]  w_y0;

    assign w_mag = r1_x[SB-1] ? SB'(-r1_x) : SB'(r1_x);
    assign n_p   = w_mag * r_g16;

    // Shifting by S0 puts x0 at 2^29; the leading one of what is left decides
    // how many further shifts keep the argument below 2^30.
    assign w_q = r2_p[PW-1:S0];

    always_comb begin
        n_e = '0;
        for (int k = 0; k < E_MAX; k++) begin
            if (w_q[30+k]) begin
                n_e = E_W'(k + 1);
            end
        end
    end

    assign w_q_sh = r3_q >> r3_e;
    assign w_x0   = X0_TOP >> r3_e;
    assign w_y0   = CORDIC_W'(w_q_sh[29:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
        r1_x    <= i_sample_in;
        r2_x    <= r1_x;
        r2_p    <= n_p;
        r3_x    <= r2_x;
        r3_zero <= (r2_p == '0);
        r3_q    <= w_q;
        r3_e    <= n_e;
    end

    // ---------------------------------------------------------- CORDIC
    t_cordic_ctl                w_cin;
    t_cordic_ctl                w_cout;
    logic [SB-1:0]              w_c_sample;
    logic signed [CORDIC_W-1:0] w_c_ang;

    assign w_cin.valid = r3_valid;
    assign w_cin.zero  = r3_zero;

    acsd_cordic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_cin),
        .i_sample (r3_x),
        .i_x      ($signed(w_x0)),
        .i_y      ($signed(w_y0)),
        .o_ctl    (w_cout),
        .o_sample (w_c_sample),
        .o_ang    (w_c_ang)
    );

    // ------------------------------------------------------- back end
    logic [30:0]          w_a;
    logic [SB-1:0]        w_ar;
    logic signed [SB:0]   w_ar_s;
    logic signed [SB:0]   n_wet;

    always_comb begin
        if (w_c_ang[CORDIC_W-1]) begin
            w_a = '0;
        end else if (w_c_ang > ANG_MAX) begin
            w_a = 31'(ANG_MAX);
        end else begin
            w_a = w_c_ang[30:0];
        end
    end

    // Angle to SB-1 fraction bits, rounding half up.
    if (SH > 0) begin : g_round
        logic [30:0] w_a_sum;
        assign w_a_sum = w_a + 31'(1 << (SH - 1));
        assign w_ar    = w_a_sum[30:SH];
    end else if (SH == 0) begin : g_exact
        assign w_ar = w_a;
    end else begin : g_widen
        assign w_ar = {w_a, {(-SH){1'b0}}};
    end

    assign w_ar_s = $signed({1'b0, w_ar});

    always_comb begin
        if (w_cout.zero) begin
            n_wet = '0;
        end else if (w_c_sample[SB-1]) begin
            n_wet = -w_ar_s;
        end else begin
            n_wet = w_ar_s;
        end
    end

    logic                     r5_valid;
    logic signed [SB-1:0]     r5_x;
    logic signed [SB:0]       r5_wet;
    logic [BLEND_W-1:0]       w_dry;
    logic signed [BLEND_W:0]  w_blend_s;
    logic signed [BLEND_W:0]  w_dry_s;
    logic signed [SB+18:0]    w_pw;
    logic signed [SB+17:0]    w_pd;
    logic signed [MIX_W-1:0]  n_mix;

    logic                     r6_valid;
    logic signed [MIX_W-1:0]  r6_mix;
    logic signed [MIX_W-1:0]  w_mix_sum;
    logic signed [M2_W-1:0]   w_m2;
    logic signed [VOL_W:0]    w_vol_s;
    logic signed [PR_W-1:0]   n_prod;

    logic                     r7_valid;
    logic signed [PR_W-1:0]   r7_prod;
    logic signed [PR_W-1:0]   w_y_sum;
    logic signed [Y_W-1:0]    w_y;

    assign w_dry     = BLEND_ONE - r_blend;
    assign w_blend_s = $signed({1'b0, r_blend});
    assign w_dry_s   = $signed({1'b0, w_dry});
    assign w_pw      = r5_wet * w_blend_s;
    assign w_pd      = r5_x * w_dry_s;
    assign n_mix     = MIX_W'(w_pw) + MIX_W'(w_pd);

    // Divide by 2^17 (blend scale and halving), rounding half up.
    assign w_mix_sum = r6_mix + MIX_HALF;
    assign w_m2      = w_mix_sum[MIX_W-1:17];
    assign w_vol_s   = $signed({1'b0, r_vol});
    assign n_prod    = w_m2 * w_vol_s;

    assign w_y_sum   = r7_prod + Y_HALF;
    assign w_y       = w_y_sum[PR_W-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r5_valid <= w_cout.valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
            o_valid  <= r7_valid;
        end
        r5_x    <= $signed(w_c_sample);
        r5_wet  <= n_wet;
        r6_mix  <= n_mix;
        r7_prod <= n_prod;
        if (w_y > SMAX) begin
            o_sample_out <= SMAX[SB-1:0];
            o_clipped    <= 1'b1;
        end else if (w_y < SMIN) begin
            o_sample_out <= SMIN[SB-1:0];
            o_clipped    <= 1'b1;
        end else begin
            o_sample_out <= w_y[SB-1:0];
            o_clipped    <= 1'b0;
        end
    end

endmodule

`default_nettype wire
